// ===== sv/dlbs_pkg.sv =====
// Shared types, constants and channel helper functions for the LED pattern sequencer.
`default_nettype none
package dlbs_pkg;

   localparam int CNT_W  = 16;   // countdown / elapsed counter width
   localparam int CFG_W  = 16;   // period register width
   localparam int STAT_W = 4;
   localparam int IDX_W  = 2;

   // status codes
   localparam logic [STAT_W-1:0] ST_NONE        = 4'd0;
   localparam logic [STAT_W-1:0] ST_POWER_UP    = 4'd1;
   localparam logic [STAT_W-1:0] ST_IDLE        = 4'd2;
   localparam logic [STAT_W-1:0] ST_ADVERTISING = 4'd3;
   localparam logic [STAT_W-1:0] ST_CONNECTED   = 4'd4;
   localparam logic [STAT_W-1:0] ST_START_MEAS  = 4'd5;
   localparam logic [STAT_W-1:0] ST_ACTIVE_MEAS = 4'd6;
   localparam logic [STAT_W-1:0] ST_STOP_MEAS   = 4'd7;
   localparam logic [STAT_W-1:0] ST_ERROR       = 4'd8;

   // register indexes
   localparam logic [IDX_W-1:0] REG_SHORT  = 2'd0;
   localparam logic [IDX_W-1:0] REG_MEDIUM = 2'd1;
   localparam logic [IDX_W-1:0] REG_LONG   = 2'd2;

   localparam logic [CFG_W-1:0] RST_SHORT  = 16'd1638;
   localparam logic [CFG_W-1:0] RST_MEDIUM = 16'd3276;
   localparam logic [CFG_W-1:0] RST_LONG   = 16'd32768;

   typedef struct packed {
      logic             led;
      logic             running;
      logic             endless;
      logic [CNT_W-1:0] period;
      logic [CNT_W-1:0] limit;
      logic [CNT_W-1:0] ticks;
      logic [CNT_W-1:0] elapsed;
   } chan_type;

   typedef struct packed {
      chan_type ch;
      logic     fin;
   } tick_type;

   typedef struct packed {
      logic [CFG_W-1:0] short_p;
      logic [CFG_W-1:0] medium_p;
      logic [CFG_W-1:0] long_p;
   } cfg_type;

   typedef struct packed {
      logic              power_led;
      logic              reset_led;
      logic              pattern_done;
      logic [STAT_W-1:0] done_status;
   } result_type;

   function automatic chan_type chan_launch(input logic [CFG_W-1:0] period,
                                            input logic [CFG_W-1:0] limit,
                                            input logic             endless);
      chan_type c;
      c.period  = CNT_W'(period);
      c.limit   = endless ? '0 : CNT_W'(limit);
      c.endless = endless;
      c.elapsed = CNT_W'(period);
      c.ticks   = CNT_W'(period);
      c.running = 1'b1;
      c.led     = 1'b1;
      return c;
   endfunction

   // One timer tick on one channel; fin set when a limited pattern runs out.
   function automatic tick_type chan_tick(input chan_type c);
      tick_type       t;
      logic [CNT_W:0] sum;
      t.ch  = c;
      t.fin = 1'b0;
      sum   = {1'b0, c.elapsed} + {1'b0, c.period};
      if (c.running) begin
         if (c.ticks != CNT_W'(1)) begin
            t.ch.ticks = c.ticks - CNT_W'(1);   // zero period wraps
         end else if (c.endless || (c.elapsed < c.limit)) begin
            t.ch.elapsed = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
            t.ch.ticks   = c.period;
            t.ch.led     = ~c.led;
         end else begin
            t.fin = 1'b1;
         end
      end
      return t;
   endfunction

endpackage
`default_nettype wire

// ===== sv/dlbs_ifs.sv =====
// Valid/ready channel interfaces: status request, LED result and register write.
`default_nettype none
interface dlbs_req_if import dlbs_pkg::*;;
   logic              valid;
   logic              ready;
   logic              action;
   logic [STAT_W-1:0] status_code;
   modport source (output valid, action, status_code, input ready);
   modport sink   (input valid, action, status_code, output ready);
endinterface

interface dlbs_rsp_if import dlbs_pkg::*;;
   logic              valid;
   logic              ready;
   logic              power_led;
   logic              reset_led;
   logic              pattern_done;
   logic [STAT_W-1:0] done_status;
   modport source (output valid, power_led, reset_led, pattern_done, done_status,
                   input ready);
   modport sink   (input valid, power_led, reset_led, pattern_done, done_status,
                   output ready);
endinterface

interface dlbs_csr_if import dlbs_pkg::*;;
   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] reg_index;
   logic [CFG_W-1:0] wdata;
   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

// ===== sv/dlbs_csr.sv =====
// Period configuration registers.
`default_nettype none
module dlbs_csr import dlbs_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   dlbs_csr_if.sink   csr_bus,
   output cfg_type    cfg
);
   cfg_type cfg_ff, cfg_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            REG_SHORT:  cfg_in.short_p  = csr_bus.wdata;
            REG_MEDIUM: cfg_in.medium_p = csr_bus.wdata;
            REG_LONG:   cfg_in.long_p   = csr_bus.wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_p  <= RST_SHORT;
         cfg_ff.medium_p <= RST_MEDIUM;
         cfg_ff.long_p   <= RST_LONG;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

// ===== sv/dlbs_engine.sv =====
// Channel state and the per-beat update for status codes and timer ticks.
`default_nettype none
module dlbs_engine import dlbs_pkg::*; (
   input  wire               clock,
   input  wire               reset,
   input  wire               step,
   input  wire               action,
   input  wire [STAT_W-1:0]  status_code,
   input  cfg_type           cfg,
   output result_type        result
);
   chan_type          pwr_ff, pwr_in, rst_ff, rst_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic              pulse_rst_ff, pulse_rst_in;
   tick_type          pwr_tick, rst_tick;
   result_type        res;

   assign pwr_tick = chan_tick(pwr_ff);
   assign rst_tick = chan_tick(rst_ff);

   always_comb begin
      pwr_in       = pwr_ff;
      rst_in       = rst_ff;
      status_in    = status_ff;
      pulse_rst_in = pulse_rst_ff;
      res          = '0;
      if (action) begin
         pwr_in    = '0;
         rst_in    = '0;
         status_in = (status_code <= ST_ERROR) ? status_code : ST_NONE;
         case (status_code)
            ST_POWER_UP:    pwr_in.led = 1'b1;
            ST_IDLE:        rst_in = chan_launch(cfg.long_p, '0, 1'b1);
            ST_ADVERTISING: pwr_in = chan_launch(cfg.medium_p, '0, 1'b1);
            ST_CONNECTED:   pwr_in = chan_launch(cfg.long_p, '0, 1'b1);
            ST_START_MEAS: begin
               pwr_in = chan_launch(cfg.short_p, cfg.long_p, 1'b0);
               rst_in = chan_launch(cfg.short_p, cfg.long_p, 1'b0);
            end
            ST_ACTIVE_MEAS: begin
               // alternate which LED gets the pulse
               if (pulse_rst_ff) begin
                  rst_in = chan_launch(cfg.medium_p, cfg.medium_p, 1'b0);
               end else begin
                  pwr_in = chan_launch(cfg.medium_p, cfg.medium_p, 1'b0);
               end
               pulse_rst_in = ~pulse_rst_ff;
            end
            ST_STOP_MEAS: begin
               pwr_in = chan_launch(cfg.long_p, cfg.long_p, 1'b0);
               rst_in = chan_launch(cfg.long_p, cfg.long_p, 1'b0);
            end
            ST_ERROR: begin
               pwr_in.led = 1'b1;
               rst_in.led = 1'b1;
            end
            default: begin
            end
         endcase
      end else if (pwr_tick.fin || rst_tick.fin) begin
         // either channel finishing halts both
         pwr_in           = '0;
         rst_in           = '0;
         res.pattern_done = 1'b1;
         res.done_status  = status_ff;
         status_in        = ST_NONE;
      end else begin
         pwr_in = pwr_tick.ch;
         rst_in = rst_tick.ch;
      end
      res.power_led = pwr_in.led;
      res.reset_led = rst_in.led;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pwr_ff       <= '0;
         rst_ff       <= '0;
         status_ff    <= ST_NONE;
         pulse_rst_ff <= 1'b1;
      end else if (step) begin
         pwr_ff       <= pwr_in;
         rst_ff       <= rst_in;
         status_ff    <= status_in;
         pulse_rst_ff <= pulse_rst_in;
      end
   end

   assign result = res;
endmodule
`default_nettype wire

// ===== sv/dual_led_blink_pattern_sequencer_core.sv =====
// Top level of the dual LED blink pattern sequencer.
//
//   channel   dir  beat payload
//   req_bus   in   action, status_code
//   rsp_bus   out  power_led, reset_led, pattern_done, done_status
//   csr_bus   in   reg_index, wdata (0 short, 1 medium, 2 long period)
//
// One beat per cycle sustained while rsp_bus is not held; a beat taken from
// req_bus is captured in the input register, then goes through the channel
// update into the result register, which drives rsp_bus.
// The result register stalls the input register while rsp_bus is held;
// csr_bus is always ready. Synchronous active-high reset restores defaults.
`default_nettype none
module dual_led_blink_pattern_sequencer_core import dlbs_pkg::*; (
   input  wire         clock,
   input  wire         reset,
   dlbs_req_if.sink    req_bus,
   dlbs_rsp_if.source  rsp_bus,
   dlbs_csr_if.sink    csr_bus
);
   cfg_type           cfg;
   result_type        result;
   logic              in_valid_ff, in_valid_in;
   logic              in_action_ff;
   logic [STAT_W-1:0] in_code_ff;
   logic              out_valid_ff, out_valid_in;
   result_type        out_data_ff;
   logic              step;

   dlbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   dlbs_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .action      (in_action_ff),
      .status_code (in_code_ff),
      .cfg         (cfg),
      .result      (result)
   );

   assign step          = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || step;
   assign in_valid_in   = req_bus.ready ? req_bus.valid : in_valid_ff;
   assign out_valid_in  = step ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_action_ff <= req_bus.action;
         in_code_ff   <= req_bus.status_code;
      end
      if (step) begin
         out_data_ff <= result;
      end
   end

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.power_led    = out_data_ff.power_led;
   assign rsp_bus.reset_led    = out_data_ff.reset_led;
   assign rsp_bus.pattern_done = out_data_ff.pattern_done;
   assign rsp_bus.done_status  = out_data_ff.done_status;
endmodule
`default_nettype wire
